>>> rtl/core/rbkd_pkg.sv
// Package: shared widths, operation codes, multiplier request type and saturation helpers.
package rbkd_pkg;

  // Widths of the item fields and of the step register.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STEP_W   = 21;
  localparam int unsigned FACTOR_W = 17;

  // Multiplier operand width (32-bit signed plus room for unsigned step and factor).
  localparam int unsigned MUL_W  = WORD_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Width of a shifted product and of the dot product accumulator.
  localparam int unsigned ACC_W = 50;

  // Reset value of the step register (about 1/60 s in Q16.16).
  localparam logic [STEP_W-1:0] STEP_TIME_RESET = STEP_W'(1092);

  // Operation codes carried in the op field.
  localparam logic [OP_W-1:0] OP_LOAD_POS = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_VEL = 3'd1;
  localparam logic [OP_W-1:0] OP_ACCEL    = 3'd2;
  localparam logic [OP_W-1:0] OP_CONTACT  = 3'd3;
  localparam logic [OP_W-1:0] OP_FINISH   = 3'd4;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    logic                    half;  // shift by 17 instead of 16
  } mul_req_t;

  // Clamp a wide signed value to the 32-bit range.
  function automatic word_t sat32(input acc_t v);
    word_t r;
    if ((&v[ACC_W-1:WORD_W-1]) || !(|v[ACC_W-1:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = WORD_MIN;
    end else begin
      r = WORD_MAX;
    end
    return r;
  endfunction

  // Saturating add of two words.
  function automatic word_t add_sat(input word_t a, input word_t b);
    acc_t s;
    s = ACC_W'(a) + ACC_W'(b);
    return sat32(s);
  endfunction

  // Saturating subtract of two words.
  function automatic word_t sub_sat(input word_t a, input word_t b);
    acc_t s;
    s = ACC_W'(a) - ACC_W'(b);
    return sat32(s);
  endfunction

  // Saturating negation: the most negative word maps to the most positive.
  function automatic word_t neg_sat(input word_t a);
    word_t r;
    if (a == WORD_MIN) begin
      r = WORD_MAX;
    end else begin
      r = -a;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/rbkd_if.sv
// Interfaces: input item channel and result item channel, valid/ready handshake.
interface rbkd_in_if;
  import rbkd_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             op;
  logic signed [WORD_W-1:0]    vec_x;
  logic signed [WORD_W-1:0]    vec_y;
  logic signed [WORD_W-1:0]    vec_z;
  logic signed [WORD_W-1:0]    penetration;
  logic                        penetration_finite;
  logic [FACTOR_W-1:0]         contact_factor;
  logic                        second_body;
  logic                        collided;

  modport source (
    output valid, op, vec_x, vec_y, vec_z, penetration, penetration_finite,
           contact_factor, second_body, collided,
    input  ready
  );

  modport sink (
    input  valid, op, vec_x, vec_y, vec_z, penetration, penetration_finite,
           contact_factor, second_body, collided,
    output ready
  );
endinterface

interface rbkd_out_if;
  import rbkd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pos_x;
  logic signed [WORD_W-1:0] pos_y;
  logic signed [WORD_W-1:0] pos_z;
  logic signed [WORD_W-1:0] vel_x;
  logic signed [WORD_W-1:0] vel_y;
  logic signed [WORD_W-1:0] vel_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    output ready
  );
endinterface

>>> rtl/core/rbkd_mul.sv
// Shared signed multiplier with a registered product and a floor shift of 16 or 17 bits.
module rbkd_mul (
  input  logic              clk,
  input  rbkd_pkg::mul_req_t req,
  output rbkd_pkg::acc_t    shifted
);
  import rbkd_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     half_r;

  // Product register; the operands come from the sequencer's mux.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
    half_r <= req.half;
  end

  // Arithmetic shift rounds toward minus infinity; the result fits the accumulator width.
  assign shifted = half_r ? ACC_W'(prod_r >>> 17) : ACC_W'(prod_r >>> 16);

endmodule

>>> rtl/core/rigid_body_kick_drift_contact.sv
// Top level: rigid body kick, drift and contact sequencer around one shared multiplier.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in_ch   | in        | valid/ready           | op, vec_x/y/z, penetration, flags, factor
//   out_ch  | out       | valid/ready           | pos_x/y/z, vel_x/y/z
//   cfg     | in        | cfg_we, no handshake  | cfg_wdata = step_time
//
// Load items need no sequence. Every product goes through the one multiplier as an operand
// issue step, then an accumulate step, one product at a time: an acceleration item runs the
// kick steps, a finish item the drift steps and the emit step, a collided contact the dot,
// normal and factor steps, plus the position steps when the penetration is finite. The block
// takes no item while a sequence runs; a finished result waits in the output register, and a
// finish item stalls only in its emit step if the previous result is still untaken. Reset is
// synchronous and clears the body state to zero and the step register to its default.
module rigid_body_kick_drift_contact (
  input  logic                        clk,
  input  logic                        rst_n,
  rbkd_in_if.sink                     in_ch,
  rbkd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [rbkd_pkg::STEP_W-1:0] cfg_wdata
);
  import rbkd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KICK_MUL,
    S_KICK_ACC,
    S_DOT_MUL,
    S_DOT_ACC,
    S_NV_MUL,
    S_NV_ACC,
    S_FAC_MUL,
    S_FAC_ACC,
    S_POS_MUL,
    S_POS_ACC,
    S_DRIFT_MUL,
    S_DRIFT_ACC,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  word_t               pos_r [3];
  word_t               pos_nxt [3];
  word_t               vel_r [3];
  word_t               vel_nxt [3];
  word_t               hk_r [3];
  word_t               hk_nxt [3];
  word_t               vec_r [3];
  word_t               vec_nxt [3];
  word_t               n_r [3];
  word_t               n_nxt [3];
  word_t               pen_r, pen_nxt;
  logic                finite_r, finite_nxt;
  logic [FACTOR_W-1:0] factor_r, factor_nxt;
  acc_t                acc_r, acc_nxt;
  word_t               d_r, d_nxt;
  word_t               nv_r, nv_nxt;
  word_t               t_r, t_nxt;
  logic                out_valid_r, out_valid_nxt;
  word_t               out_pos_r [3];
  word_t               out_pos_nxt [3];
  word_t               out_vel_r [3];
  word_t               out_vel_nxt [3];

  mul_req_t mul_req;
  acc_t     mul_sh;
  word_t    mul_sat;
  logic     in_fire;
  logic     last_idx;
  logic     out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign last_idx = (idx_r == 2'd2);
  assign out_free = !out_valid_r || out_ch.ready;
  assign mul_sat  = sat32(mul_sh);

  // Shared multiplier.
  rbkd_mul u_mul (
    .clk     (clk),
    .req     (mul_req),
    .shifted (mul_sh)
  );

  // Operand select for the product issued in each multiply state.
  always_comb begin
    mul_req.a    = MUL_W'(vel_r[idx_r]);
    mul_req.b    = signed'({{(MUL_W-STEP_W){1'b0}}, step_r});
    mul_req.half = 1'b0;
    unique case (state_r)
      S_KICK_MUL: begin
        mul_req.a    = MUL_W'(vec_r[idx_r]);
        mul_req.half = 1'b1;
      end
      S_DOT_MUL: begin
        mul_req.b = MUL_W'(n_r[idx_r]);
      end
      S_NV_MUL: begin
        mul_req.a = MUL_W'(n_r[idx_r]);
        mul_req.b = MUL_W'(d_r);
      end
      S_FAC_MUL: begin
        mul_req.a = MUL_W'(nv_r);
        mul_req.b = signed'({{(MUL_W-FACTOR_W){1'b0}}, factor_r});
      end
      S_POS_MUL: begin
        mul_req.a = MUL_W'(vec_r[idx_r]);
        mul_req.b = MUL_W'(pen_r);
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    hk_nxt        = hk_r;
    vec_nxt       = vec_r;
    n_nxt         = n_r;
    pen_nxt       = pen_r;
    finite_nxt    = finite_r;
    factor_nxt    = factor_r;
    acc_nxt       = acc_r;
    d_nxt         = d_r;
    nv_nxt        = nv_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_vel_nxt   = out_vel_r;

    // The result leaves when the sink takes it.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      step_nxt = cfg_wdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Capture the item and start the sequence for its operation.
          vec_nxt[0] = in_ch.vec_x;
          vec_nxt[1] = in_ch.vec_y;
          vec_nxt[2] = in_ch.vec_z;
          n_nxt[0]   = in_ch.second_body ? neg_sat(in_ch.vec_x) : in_ch.vec_x;
          n_nxt[1]   = in_ch.second_body ? neg_sat(in_ch.vec_y) : in_ch.vec_y;
          n_nxt[2]   = in_ch.second_body ? neg_sat(in_ch.vec_z) : in_ch.vec_z;
          pen_nxt    = in_ch.penetration;
          finite_nxt = in_ch.penetration_finite;
          factor_nxt = in_ch.contact_factor;
          acc_nxt    = '0;
          idx_nxt    = 2'd0;
          case (in_ch.op)
            OP_LOAD_POS: begin
              pos_nxt[0] = in_ch.vec_x;
              pos_nxt[1] = in_ch.vec_y;
              pos_nxt[2] = in_ch.vec_z;
            end
            OP_LOAD_VEL: begin
              vel_nxt[0] = in_ch.vec_x;
              vel_nxt[1] = in_ch.vec_y;
              vel_nxt[2] = in_ch.vec_z;
            end
            OP_ACCEL: begin
              state_nxt = S_KICK_MUL;
            end
            OP_CONTACT: begin
              if (in_ch.collided) begin
                state_nxt = S_DOT_MUL;
              end
            end
            OP_FINISH: begin
              state_nxt = S_DRIFT_MUL;
            end
            default: begin
            end
          endcase
        end
      end

      // First half kick: store acc*step/2 and add it to the velocity.
      S_KICK_MUL: state_nxt = S_KICK_ACC;
      S_KICK_ACC: begin
        hk_nxt[idx_r]  = mul_sat;
        vel_nxt[idx_r] = add_sat(vel_r[idx_r], mul_sat);
        idx_nxt        = last_idx ? 2'd0 : idx_r + 2'd1;
        state_nxt      = last_idx ? S_IDLE : S_KICK_MUL;
      end

      // Dot product of velocity and normal, summed exactly then clamped.
      S_DOT_MUL: state_nxt = S_DOT_ACC;
      S_DOT_ACC: begin
        acc_nxt = acc_r + mul_sh;
        if (last_idx) begin
          d_nxt     = sat32(acc_r + mul_sh);
          idx_nxt   = 2'd0;
          state_nxt = S_NV_MUL;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_DOT_MUL;
        end
      end

      // Normal component and tangential remainder of one axis.
      S_NV_MUL: state_nxt = S_NV_ACC;
      S_NV_ACC: begin
        nv_nxt    = mul_sat;
        t_nxt     = sub_sat(vel_r[idx_r], mul_sat);
        state_nxt = S_FAC_MUL;
      end

      // Scaled normal component plus tangential part.
      S_FAC_MUL: state_nxt = S_FAC_ACC;
      S_FAC_ACC: begin
        vel_nxt[idx_r] = add_sat(mul_sat, t_r);
        if (last_idx) begin
          idx_nxt   = 2'd0;
          state_nxt = finite_r ? S_POS_MUL : S_IDLE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_NV_MUL;
        end
      end

      // Push the position out along the unflipped normal.
      S_POS_MUL: state_nxt = S_POS_ACC;
      S_POS_ACC: begin
        pos_nxt[idx_r] = add_sat(pos_r[idx_r], mul_sat);
        idx_nxt        = last_idx ? 2'd0 : idx_r + 2'd1;
        state_nxt      = last_idx ? S_IDLE : S_POS_MUL;
      end

      // Drift by velocity*step, then the second half kick.
      S_DRIFT_MUL: state_nxt = S_DRIFT_ACC;
      S_DRIFT_ACC: begin
        pos_nxt[idx_r] = add_sat(pos_r[idx_r], mul_sat);
        vel_nxt[idx_r] = add_sat(vel_r[idx_r], hk_r[idx_r]);
        idx_nxt        = last_idx ? 2'd0 : idx_r + 2'd1;
        state_nxt      = last_idx ? S_EMIT : S_DRIFT_MUL;
      end

      // Hand the body to the output register once it is free.
      S_EMIT: begin
        if (out_free) begin
          out_pos_nxt   = pos_r;
          out_vel_nxt   = vel_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      step_r      <= STEP_TIME_RESET;
      pos_r       <= '{default: '0};
      vel_r       <= '{default: '0};
      hk_r        <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      hk_r        <= hk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    vec_r     <= vec_nxt;
    n_r       <= n_nxt;
    pen_r     <= pen_nxt;
    finite_r  <= finite_nxt;
    factor_r  <= factor_nxt;
    acc_r     <= acc_nxt;
    d_r       <= d_nxt;
    nv_r      <= nv_nxt;
    t_r       <= t_nxt;
    out_pos_r <= out_pos_nxt;
    out_vel_r <= out_vel_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = out_pos_r[0];
  assign out_ch.pos_y = out_pos_r[1];
  assign out_ch.pos_z = out_pos_r[2];
  assign out_ch.vel_x = out_vel_r[0];
  assign out_ch.vel_y = out_vel_r[1];
  assign out_ch.vel_z = out_vel_r[2];

  // A result appears only from the emit step.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside the emit step");

  // The emit step never overwrites an untaken result.
  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ch.ready) |=> state_r == S_EMIT)
    else $error("emit left while the output register was full");

  // The axis counter stays within the three axes.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd3)
    else $error("axis counter out of range");

  // A finish item starts the drift sequence at the first axis.
  a_finish_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.op == OP_FINISH) |=> (state_r == S_DRIFT_MUL && idx_r == 2'd0))
    else $error("finish item did not start the drift");

endmodule
